[sv/nrr_pkg.sv]
`default_nettype none

package nrr_pkg;

  localparam int DIV_W     = 64;
  localparam int NUM_W     = 23;
  localparam int RECIP_W   = 41;
  localparam int RATIO_W   = 63;
  localparam int PROD_W    = NUM_W + RECIP_W;
  localparam int STEPS_W   = 4;
  localparam int SHIFT_W   = 7;
  localparam int MAX_STEPS = 15;
  localparam int GROUPS    = DIV_W / 8;
  localparam int NORM_LAT  = 5;
  localparam int STEP_LAT  = 4;
  localparam int BACK_LAT  = 2;

  localparam logic [STEPS_W-1:0] STEPS_RESET = 4'd6;

  typedef struct packed {
    logic [DIV_W-1:0] divisor;
    logic [NUM_W-1:0] numerator;
  } nrr_in_t;

  typedef struct packed {
    logic [RECIP_W-1:0] reciprocal;
    logic [RATIO_W-1:0] ratio;
    logic               divide_error;
  } nrr_out_t;

  // Per-request sideband that rides along the Newton stages.
  typedef struct packed {
    logic               err;
    logic [SHIFT_W-1:0] p;
    logic [NUM_W-1:0]   num;
  } nrr_side_t;

  // Position of the highest set bit of a byte (0 for an empty byte).
  function automatic logic [2:0] msb8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        n = 3'(i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[sv/nrr_norm.sv]
`default_nettype none

// Range reduction: p = ceil(log2(x)), x' = x scaled to (0.5,1], seed y = 3 - 2x'.
module nrr_norm #(
  parameter int FRAC_BITS = 40
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire nrr_pkg::nrr_in_t       in_data,
  output logic                        out_valid,
  output logic [FRAC_BITS+2:0]        out_xp,
  output logic [FRAC_BITS+2:0]        out_y,
  output nrr_pkg::nrr_side_t          out_side
);

  localparam int W  = FRAC_BITS + 3;
  localparam int SW = nrr_pkg::SHIFT_W;
  localparam logic [W-1:0]  THREE = W'(3) << FRAC_BITS;
  localparam logic [SW-1:0] FB    = SW'(FRAC_BITS);

  // stage 1: x - 1 (p = 64 - lzc(x - 1) covers x = 1 and x = 0 alike)
  logic                         s1_vld_r;
  logic [nrr_pkg::DIV_W-1:0]    s1_x_r, s1_xm1_r;
  nrr_pkg::nrr_side_t           s1_side_r, s1_side_nxt;

  // stage 2: per-byte occupancy and msb position
  logic                         s2_vld_r;
  logic [nrr_pkg::DIV_W-1:0]    s2_x_r;
  nrr_pkg::nrr_side_t           s2_side_r;
  logic [nrr_pkg::GROUPS-1:0]   s2_nz_r, s2_nz_nxt;
  logic [2:0]                   s2_msb_r [nrr_pkg::GROUPS];
  logic [2:0]                   s2_msb_nxt [nrr_pkg::GROUPS];

  // stage 3: p
  logic                         s3_vld_r;
  logic [nrr_pkg::DIV_W-1:0]    s3_x_r;
  nrr_pkg::nrr_side_t           s3_side_r, s3_side_nxt;

  // stage 4: x'
  logic                         s4_vld_r;
  nrr_pkg::nrr_side_t           s4_side_r;
  logic [W-1:0]                 s4_xp_r, s4_xp_nxt;

  // stage 5: seed
  logic                         s5_vld_r;
  nrr_pkg::nrr_side_t           s5_side_r;
  logic [W-1:0]                 s5_xp_r, s5_y_r, s5_y_nxt;

  always_comb begin
    s1_side_nxt     = '0;
    s1_side_nxt.err = (in_data.divisor == '0);
    s1_side_nxt.num = in_data.numerator;
  end

  always_comb begin
    for (int g = 0; g < nrr_pkg::GROUPS; g++) begin
      s2_nz_nxt[g]  = |s1_xm1_r[g*8 +: 8];
      s2_msb_nxt[g] = nrr_pkg::msb8(s1_xm1_r[g*8 +: 8]);
    end
  end

  always_comb begin
    s3_side_nxt   = s2_side_r;
    s3_side_nxt.p = '0;
    // highest occupied byte wins
    for (int g = 0; g < nrr_pkg::GROUPS; g++) begin
      if (s2_nz_r[g]) begin
        s3_side_nxt.p = SW'(g * 8 + 1) + SW'(s2_msb_r[g]);
      end
    end
  end

  always_comb begin
    if (s3_side_r.p <= FB) begin
      s4_xp_nxt = W'(s3_x_r) << (FB - s3_side_r.p);
    end else begin
      s4_xp_nxt = W'(s3_x_r >> (s3_side_r.p - FB));
    end
  end

  assign s5_y_nxt = THREE - (s4_xp_r << 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r    <= in_data.divisor;
    s1_xm1_r  <= in_data.divisor - nrr_pkg::DIV_W'(1);
    s1_side_r <= s1_side_nxt;
    s2_x_r    <= s1_x_r;
    s2_side_r <= s1_side_r;
    s2_nz_r   <= s2_nz_nxt;
    s2_msb_r  <= s2_msb_nxt;
    s3_x_r    <= s2_x_r;
    s3_side_r <= s3_side_nxt;
    s4_side_r <= s3_side_r;
    s4_xp_r   <= s4_xp_nxt;
    s5_side_r <= s4_side_r;
    s5_xp_r   <= s4_xp_r;
    s5_y_r    <= s5_y_nxt;
  end

  assign out_valid = s5_vld_r;
  assign out_xp    = s5_xp_r;
  assign out_y     = s5_y_r;
  assign out_side  = s5_side_r;

endmodule

`default_nettype wire

[sv/nrr_step.sv]
`default_nettype none

// One Newton step y = y * (2 - x'y) over four stages (y held when step_en is low);
// each product is split into two partial products (halves of one operand), summed in the next stage.
module nrr_step #(
  parameter int FRAC_BITS = 40
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step_en,
  input  wire logic                   in_valid,
  input  wire logic [FRAC_BITS+2:0]   in_xp,
  input  wire logic [FRAC_BITS+2:0]   in_y,
  input  wire nrr_pkg::nrr_side_t     in_side,
  output logic                        out_valid,
  output logic [FRAC_BITS+2:0]        out_xp,
  output logic [FRAC_BITS+2:0]        out_y,
  output nrr_pkg::nrr_side_t          out_side
);

  localparam int W   = FRAC_BITS + 3;
  localparam int LO  = W / 2;
  localparam int HI  = W - LO;
  localparam int PLW = W + LO;
  localparam int PHW = W + HI;
  localparam int PW  = 2 * W;
  localparam logic [W-1:0] TWO = W'(2) << FRAC_BITS;

  logic               a_vld_r, b_vld_r, c_vld_r, d_vld_r;
  logic [W-1:0]       a_xp_r, b_xp_r, c_xp_r, d_xp_r;
  logic [W-1:0]       a_y_r, b_y_r, c_y_r, d_y_r, d_y_nxt;
  nrr_pkg::nrr_side_t a_side_r, b_side_r, c_side_r, d_side_r;
  logic [PLW-1:0]     a_plo_r, a_plo_nxt, c_plo_r, c_plo_nxt;
  logic [PHW-1:0]     a_phi_r, a_phi_nxt, c_phi_r, c_phi_nxt;
  logic [W-1:0]       b_corr_r, b_corr_nxt;
  logic [PW-1:0]      xy_full, yn_full;
  logic [W-1:0]       xy, yn;

  assign a_plo_nxt = PLW'(in_xp) * PLW'(in_y[LO-1:0]);
  assign a_phi_nxt = PHW'(in_xp) * PHW'(in_y[W-1:LO]);

  assign xy_full    = PW'(a_plo_r) + (PW'(a_phi_r) << LO);
  assign xy         = xy_full[FRAC_BITS +: W];
  assign b_corr_nxt = (xy >= TWO) ? '0 : TWO - xy;

  assign c_plo_nxt = PLW'(b_y_r) * PLW'(b_corr_r[LO-1:0]);
  assign c_phi_nxt = PHW'(b_y_r) * PHW'(b_corr_r[W-1:LO]);

  assign yn_full = PW'(c_plo_r) + (PW'(c_phi_r) << LO);
  assign yn      = yn_full[FRAC_BITS +: W];
  assign d_y_nxt = step_en ? yn : c_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_xp_r   <= in_xp;
    a_y_r    <= in_y;
    a_side_r <= in_side;
    a_plo_r  <= a_plo_nxt;
    a_phi_r  <= a_phi_nxt;
    b_xp_r   <= a_xp_r;
    b_y_r    <= a_y_r;
    b_side_r <= a_side_r;
    b_corr_r <= b_corr_nxt;
    c_xp_r   <= b_xp_r;
    c_y_r    <= b_y_r;
    c_side_r <= b_side_r;
    c_plo_r  <= c_plo_nxt;
    c_phi_r  <= c_phi_nxt;
    d_xp_r   <= c_xp_r;
    d_y_r    <= d_y_nxt;
    d_side_r <= c_side_r;
  end

  assign out_valid = d_vld_r;
  assign out_xp    = d_xp_r;
  assign out_y     = d_y_r;
  assign out_side  = d_side_r;

endmodule

`default_nettype wire

[sv/newton_fixed_point_reciprocal.sv]
// Pipeline: 5 range-reduction stages, 15 Newton slots of 4 stages and 2 output
//   stages lie between an accepted request and its out_valid strobe.
// Throughput: one request per cycle; busy is always low and every Newton slot
//   is present whatever steps_r holds (unused slots pass y through).
// Results are shown for one cycle and cannot be stalled by the receiver.
// Reset clears all valid bits and loads steps_r with 6.
`default_nettype none

module newton_fixed_point_reciprocal #(
  parameter int FRAC_BITS = 40
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire nrr_pkg::nrr_in_t                in_data,
  output logic                                 out_valid,
  output nrr_pkg::nrr_out_t                    out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [nrr_pkg::STEPS_W-1:0]     cfg_data
);

  localparam int W   = FRAC_BITS + 3;
  localparam int NS  = nrr_pkg::MAX_STEPS;
  localparam int LAT = nrr_pkg::NORM_LAT + NS * nrr_pkg::STEP_LAT + nrr_pkg::BACK_LAT;

  logic [nrr_pkg::STEPS_W-1:0] steps_r;

  logic               ch_vld  [NS+1];
  logic [W-1:0]       ch_xp   [NS+1];
  logic [W-1:0]       ch_y    [NS+1];
  nrr_pkg::nrr_side_t ch_side [NS+1];

  logic                        r1_vld_r, r1_err_r;
  logic [nrr_pkg::NUM_W-1:0]   r1_num_r;
  logic [nrr_pkg::RECIP_W-1:0] r1_recip_r, r1_recip_nxt;
  logic                        out_valid_r;
  nrr_pkg::nrr_out_t           out_data_r, out_data_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= nrr_pkg::STEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      steps_r <= cfg_data;
    end
  end

  nrr_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_data   (in_data),
    .out_valid (ch_vld[0]),
    .out_xp    (ch_xp[0]),
    .out_y     (ch_y[0]),
    .out_side  (ch_side[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_step
    nrr_step #(.FRAC_BITS(FRAC_BITS)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .step_en   (steps_r > nrr_pkg::STEPS_W'(i)),
      .in_valid  (ch_vld[i]),
      .in_xp     (ch_xp[i]),
      .in_y      (ch_y[i]),
      .in_side   (ch_side[i]),
      .out_valid (ch_vld[i+1]),
      .out_xp    (ch_xp[i+1]),
      .out_y     (ch_y[i+1]),
      .out_side  (ch_side[i+1])
    );
  end

  // p = 64 leaves nothing after the final shift; a zero divisor forces zero.
  always_comb begin
    if (ch_side[NS].err || ch_side[NS].p[nrr_pkg::SHIFT_W-1]) begin
      r1_recip_nxt = '0;
    end else begin
      r1_recip_nxt = nrr_pkg::RECIP_W'(ch_y[NS] >> ch_side[NS].p);
    end
  end

  always_comb begin
    out_data_nxt.reciprocal   = r1_recip_r;
    out_data_nxt.ratio        = nrr_pkg::RATIO_W'(nrr_pkg::PROD_W'(r1_num_r)
                                                 * nrr_pkg::PROD_W'(r1_recip_r));
    out_data_nxt.divide_error = r1_err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      r1_vld_r    <= ch_vld[NS];
      out_valid_r <= r1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    r1_err_r   <= ch_side[NS].err;
    r1_num_r   <= ch_side[NS].num;
    r1_recip_r <= r1_recip_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_follows_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching request");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.divide_error) |->
      (out_data.reciprocal == '0 && out_data.ratio == '0))
    else $error("divide error with nonzero outputs");

  a_err_tracks_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.divide_error == $past(in_data.divisor == '0, LAT)))
    else $error("divide error does not match divisor");

endmodule

`default_nettype wire

[test/nrr_recip_checker.sv]
`timescale 1ns / 100ps

module nrr_recip_checker #(
  parameter int FRAC_BITS = 40
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  nrr_pkg::nrr_in_t            in_data,
  input  logic                        out_valid,
  input  nrr_pkg::nrr_out_t           out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [nrr_pkg::STEPS_W-1:0] cfg_data,
  output int                          pending,
  output int                          mismatches,
  output int                          results_checked
);

  // well above the number of requests the pipeline can hold
  localparam int DEPTH = 128;

  logic [nrr_pkg::STEPS_W-1:0] steps_copy = nrr_pkg::STEPS_RESET;
  nrr_pkg::nrr_out_t           expected_quotients [DEPTH];
  int                          rd_pos, wr_pos, held;

  // (a * b) >> FRAC_BITS over the full 128-bit product, kept to 64 bits
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[FRAC_BITS +: 64];
  endfunction

  function automatic nrr_pkg::nrr_out_t reciprocal_of(
      input nrr_pkg::nrr_in_t req, input logic [nrr_pkg::STEPS_W-1:0] steps);
    nrr_pkg::nrr_out_t r;
    logic [63:0]       one, two, xp, y, xy, corr, recip, prod;
    int                p;
    r = '0;
    if (req.divisor == '0) begin
      r.divide_error = 1'b1;
      return r;
    end
    one = 64'd1 << FRAC_BITS;
    two = one << 1;
    p = 0;
    while (p < 64 && (64'd1 << p) < req.divisor) p++;
    if (p <= FRAC_BITS) begin
      xp = req.divisor << (FRAC_BITS - p);
    end else begin
      xp = req.divisor >> (p - FRAC_BITS);
    end
    // seed 3 - 2x', then y = y * (2 - x'y)
    y = 64'd3 * one - (xp << 1);
    for (int t = 0; t < int'(steps); t++) begin
      xy   = fx_mul(xp, y);
      corr = (xy >= two) ? 64'd0 : two - xy;
      y    = fx_mul(y, corr);
    end
    recip = (p >= 64) ? 64'd0 : (y >> p);
    r.reciprocal = recip[nrr_pkg::RECIP_W-1:0];
    prod = req.numerator * r.reciprocal;
    r.ratio = prod[nrr_pkg::RATIO_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    nrr_pkg::nrr_out_t want;
    if (!rst_n) begin
      steps_copy = nrr_pkg::STEPS_RESET;
      rd_pos = 0;
      wr_pos = 0;
      held = 0;
      mismatches = 0;
      results_checked = 0;
    end else begin
      if (out_valid) begin
        if (held == 0) begin
          mismatches++;
          $display("%0t: result with no request pending: recip=%h ratio=%h err=%b",
                   $time, out_data.reciprocal, out_data.ratio, out_data.divide_error);
        end else begin
          want = expected_quotients[rd_pos];
          rd_pos = (rd_pos + 1) % DEPTH;
          held--;
          results_checked++;
          if (out_data.reciprocal !== want.reciprocal) begin
            mismatches++;
            $display("%0t: reciprocal expected %h got %h",
                     $time, want.reciprocal, out_data.reciprocal);
          end
          if (out_data.ratio !== want.ratio) begin
            mismatches++;
            $display("%0t: ratio expected %h got %h", $time, want.ratio, out_data.ratio);
          end
          if (out_data.divide_error !== want.divide_error) begin
            mismatches++;
            $display("%0t: divide_error expected %b got %b",
                     $time, want.divide_error, out_data.divide_error);
          end
        end
      end
      if (start && !busy) begin
        if (held == DEPTH) begin
          mismatches++;
          $display("%0t: too many requests in flight: expected at most %0d got %0d",
                   $time, DEPTH, held + 1);
        end else begin
          expected_quotients[wr_pos] = reciprocal_of(in_data, steps_copy);
          wr_pos = (wr_pos + 1) % DEPTH;
          held++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        steps_copy = cfg_data;
      end
    end
    pending <= held;
  end

endmodule

[test/newton_fixed_point_reciprocal_tb.sv]
`timescale 1ns / 100ps

module newton_fixed_point_reciprocal_tb;

  localparam int FRAC_BITS    = 40;
  localparam int SETTLE       = 80;   // a bit over the pipeline depth
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 150;

  localparam logic [63:0] EDGE_DIVISORS [18] = '{
    64'd0, 64'd1, 64'd2, 64'd3, 64'd5, 64'd7, 64'd1000,
    64'h0000_0100_0000_0000, 64'h0000_0100_0000_0001, 64'h0000_01FF_FFFF_FFFF,
    64'h4000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555, 64'h0000_0000_FFFF_FFFF
  };
  localparam int PHASE_STEPS [PHASES] = '{0, 15, 1, 8, 6, 15, 3};
  localparam int PHASE_IDLE  [PHASES] = '{0, 77, 30, 0, 77, 30, 0};

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  nrr_pkg::nrr_in_t            in_data = '0;
  logic                        out_valid;
  nrr_pkg::nrr_out_t           out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [nrr_pkg::STEPS_W-1:0] cfg_data = '0;

  int pending, mismatches, results_checked;
  int sent = 0;
  int idle_pct = 0;

  newton_fixed_point_reciprocal #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  nrr_recip_checker #(.FRAC_BITS(FRAC_BITS)) recip_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .pending         (pending),
    .mismatches      (mismatches),
    .results_checked (results_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] pick_divisor();
    logic [63:0] v;
    int          k;
    v = {$urandom(), $urandom()};
    k = $urandom_range(63);
    case ($urandom_range(19))
      0: v = '0;
      1, 2: v = 64'($urandom_range(1, 1000));
      3, 4: v = 64'd1 << k;
      5, 6: v = (64'd1 << k) + 64'($urandom_range(2)) - 64'd1;
      7, 8: v[63] = 1'b1;
      9, 10, 11, 12: v = v >> k;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [nrr_pkg::NUM_W-1:0] pick_numerator();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return nrr_pkg::NUM_W'($urandom());
    endcase
  endfunction

  task automatic send_divide(input logic [63:0] d, input logic [nrr_pkg::NUM_W-1:0] n);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= '{divisor: d, numerator: n};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  // stop sending until every result is back, then let the pipeline settle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_steps(input logic [nrr_pkg::STEPS_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset step count, no gaps
    foreach (EDGE_DIVISORS[i]) begin
      case (i % 3)
        0: send_divide(EDGE_DIVISORS[i], '0);
        1: send_divide(EDGE_DIVISORS[i], '1);
        default: send_divide(EDGE_DIVISORS[i], pick_numerator());
      endcase
    end
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_steps(nrr_pkg::STEPS_W'(PHASE_STEPS[ph]));
      idle_pct = PHASE_IDLE[ph];
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 2 && i == PHASE_ITEMS / 2) drain();
        send_divide(pick_divisor(), pick_numerator());
      end
      drain();
    end

    $display("Sent %0d requests, %0d results checked, step counts 0 to 15 incl. reset value.",
             sent, results_checked);
    $display("Divisors: zero, powers of two and neighbors, above 2^63, full range; gaps 0-77%%.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
